>>> rtl/c25519_pkg.sv
// Shared types, operation codes and the exponent chain program for the Curve25519 field ALU.
package c25519_pkg;

    // Word accepted on the operation channel.
    typedef struct packed {
        logic [3:0]  func;
        logic [63:0] a0;
        logic [63:0] a1;
        logic [63:0] a2;
        logic [63:0] a3;
        logic [63:0] b0;
        logic [63:0] b1;
        logic [63:0] b2;
        logic [63:0] b3;
    } op_word_t;

    // Word delivered on the result channel.
    typedef struct packed {
        logic [63:0] r0;
        logic [63:0] r1;
        logic [63:0] r2;
        logic [63:0] r3;
        logic        is_nonzero;
        logic        is_odd;
    } res_word_t;

    // Operation codes.
    localparam logic [3:0] FN_ADD   = 4'd0;
    localparam logic [3:0] FN_SUB   = 4'd1;
    localparam logic [3:0] FN_MUL   = 4'd2;
    localparam logic [3:0] FN_SQR   = 4'd3;
    localparam logic [3:0] FN_M121  = 4'd4;
    localparam logic [3:0] FN_NEG   = 4'd5;
    localparam logic [3:0] FN_INV   = 4'd6;
    localparam logic [3:0] FN_POW58 = 4'd7;
    localparam logic [3:0] FN_CANON = 4'd8;
    localparam logic [3:0] FN_LOAD  = 4'd9;

    // Source of the per-limb raw value fed to the fold.
    localparam logic [1:0] VS_ADD  = 2'd0;
    localparam logic [1:0] VS_SUB  = 2'd1;
    localparam logic [1:0] VS_MUL  = 2'd2;
    localparam logic [1:0] VS_M121 = 2'd3;

    // Working registers of the exponent chains.
    localparam logic [2:0] SL_Z = 3'd0;
    localparam logic [2:0] SL_E = 3'd1;
    localparam logic [2:0] SL_S = 3'd2;
    localparam logic [2:0] SL_K = 3'd3;
    localparam logic [2:0] SL_W = 3'd4;
    localparam int         SLOT_COUNT = 5;

    localparam logic [4:0]   STEP_LAST = 5'd21;
    localparam logic [255:0] PRIME     = (256'd1 << 255) - 256'd19;
    localparam logic [16:0]  K121666   = 17'd121666;
    localparam logic [5:0]   K38       = 6'd38;
    localparam logic [4:0]   K19       = 5'd19;

    // One step of an exponent chain: a multiply, or n squarings.
    typedef struct packed {
        logic       sqr;
        logic [2:0] a;
        logic [2:0] b;
        logic [2:0] dst;
        logic [6:0] n;
    } step_t;

    // 32-bit limb of 3p used by subtraction.
    function automatic logic [33:0] three_p_limb(input logic [2:0] idx);
        logic [33:0] v;
        begin
            case (idx)
                3'd0:    v = 34'h2ffffffc7;
                3'd7:    v = 34'h17ffffffd;
                default: v = 34'h2fffffffd;
            endcase
            return v;
        end
    endfunction

    function automatic step_t mk_sqr(input logic [2:0] a, input logic [2:0] dst,
                                     input logic [6:0] n);
        step_t s;
        begin
            s.sqr = 1'b1;
            s.a   = a;
            s.b   = a;
            s.dst = dst;
            s.n   = n;
            return s;
        end
    endfunction

    function automatic step_t mk_mul(input logic [2:0] a, input logic [2:0] b,
                                     input logic [2:0] dst);
        step_t s;
        begin
            s.sqr = 1'b0;
            s.a   = a;
            s.b   = b;
            s.dst = dst;
            s.n   = 7'd1;
            return s;
        end
    endfunction

    // Addition chains for z^(p-2) and z^((p-5)/8); the result ends in SL_S.
    function automatic step_t chain_step(input logic pow, input logic [4:0] idx);
        step_t s;
        begin
            unique case (idx)
                5'd0:  s = pow ? mk_sqr(SL_Z, SL_S, 7'd1) : mk_sqr(SL_Z, SL_E, 7'd1);
                5'd1:  s = pow ? mk_sqr(SL_S, SL_W, 7'd2) : mk_sqr(SL_E, SL_S, 7'd2);
                5'd2:  s = pow ? mk_mul(SL_Z, SL_W, SL_W) : mk_mul(SL_Z, SL_S, SL_S);
                5'd3:  s = pow ? mk_mul(SL_S, SL_W, SL_S) : mk_mul(SL_E, SL_S, SL_E);
                5'd4:  s = pow ? mk_sqr(SL_S, SL_S, 7'd1) : mk_sqr(SL_E, SL_W, 7'd1);
                5'd5:  s = mk_mul(SL_W, SL_S, SL_S);
                5'd6:  s = mk_sqr(SL_S, SL_W, 7'd5);
                5'd7:  s = mk_mul(SL_W, SL_S, SL_S);
                5'd8:  s = mk_sqr(SL_S, SL_W, 7'd10);
                5'd9:  s = mk_mul(SL_W, SL_S, SL_W);
                5'd10: s = mk_sqr(SL_W, SL_K, 7'd20);
                5'd11: s = mk_mul(SL_K, SL_W, SL_W);
                5'd12: s = mk_sqr(SL_W, SL_W, 7'd10);
                5'd13: s = mk_mul(SL_W, SL_S, SL_S);
                5'd14: s = mk_sqr(SL_S, SL_W, 7'd50);
                5'd15: s = mk_mul(SL_W, SL_S, SL_W);
                5'd16: s = mk_sqr(SL_W, SL_K, 7'd100);
                5'd17: s = mk_mul(SL_K, SL_W, SL_W);
                5'd18: s = mk_sqr(SL_W, SL_W, 7'd50);
                5'd19: s = mk_mul(SL_W, SL_S, SL_S);
                5'd20: s = pow ? mk_sqr(SL_S, SL_S, 7'd2) : mk_sqr(SL_S, SL_S, 7'd5);
                5'd21: s = pow ? mk_mul(SL_S, SL_Z, SL_S) : mk_mul(SL_S, SL_E, SL_S);
                default: s = mk_mul(SL_Z, SL_Z, SL_S);
            endcase
            return s;
        end
    endfunction

endpackage

>>> rtl/curve25519_field_alu_unit.sv
// Curve25519 field ALU: one 32x32 multiplier and a limb-serial fold under a small sequencer.
//
// Usage: an operation word (code plus two 256-bit operands) is taken on the op
// channel when op_valid is high and op_stall is low. One result word leaves on
// the res channel when res_valid is high and res_stall is low.
// The unit works on one word at a time and holds op_stall high while busy.
// Steps per word, from acceptance to the result register:
//   add, sub, negate, times121666: two passes of 8 limbs through the fold,
//   then the finish step.
//   mul, square: 64 partial products on the one 32x32 multiplier, then the
//   top limb, the fold and the finish step.
//   invert: 254 squarings and 11 multiplies, each loading its operands and then run as a mul.
//   pow (p-5)/8: 251 squarings and 11 multiplies.
//   canonical: conditional subtraction of p, then the finish step; load and unused codes: the finish step only.
// The multiplier and fold are shared by every step, so the chains set the rate.
// A finished result sits in the output register; the next word is accepted
// while it waits. If the receiver stalls, the unit holds the newer result
// internally until the output register frees.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops res_valid.
module curve25519_field_alu_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 op_valid,
    output logic                 op_stall,
    input  c25519_pkg::op_word_t op,
    output logic                 res_valid,
    input  logic                 res_stall,
    output c25519_pkg::res_word_t res
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_LDA  = 9'b000000010,
        ST_LDB  = 9'b000000100,
        ST_MUL  = 9'b000001000,
        ST_MTOP = 9'b000010000,
        ST_RED1 = 9'b000100000,
        ST_RED2 = 9'b001000000,
        ST_CAN  = 9'b010000000,
        ST_DONE = 9'b100000000
    } state_t;

    // Lowest and highest row index of a product column.
    function automatic logic [2:0] col_lo(input logic [3:0] k);
        begin
            return (k > 4'd7) ? (k[2:0] + 3'd1) : 3'd0;
        end
    endfunction

    function automatic logic [2:0] col_hi(input logic [3:0] k);
        begin
            return (k < 4'd7) ? k[2:0] : 3'd7;
        end
    endfunction

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic [3:0]  k_reg, k_next;
    logic [2:0]  i_reg, i_next;
    logic [2:0]  ri_reg, ri_next;
    logic [4:0]  step_reg, step_next;
    logic [6:0]  iter_reg, iter_next;
    logic        chain_reg, chain_next;
    logic        pow_reg, pow_next;
    logic        can_reg, can_next;
    logic        cpass_reg, cpass_next;
    logic [1:0]  vsel_reg, vsel_next;

    logic [255:0] opx_reg, opx_next;
    logic [255:0] opy_reg, opy_next;
    logic [511:0] t_reg, t_next;
    logic [255:0] w_reg, w_next;
    logic [69:0]  acc_reg, acc_next;
    logic [63:0]  carry_reg, carry_next;
    c25519_pkg::res_word_t out_reg, out_next;

    logic [255:0] slot_reg [c25519_pkg::SLOT_COUNT];
    logic         slot_we;
    logic [2:0]   slot_wa;
    logic [255:0] slot_wd;
    logic [2:0]   slot_ra;
    logic [255:0] slot_rd;

    c25519_pkg::step_t st;
    logic [255:0] a_val, b_val;
    logic [2:0]   col_j;
    logic [31:0]  x_limb, y_limb;
    logic [63:0]  prod;
    logic [69:0]  msum;
    logic [31:0]  rx, ry;
    logic [63:0]  v_limb;
    logic [63:0]  u1, u2;
    logic [256:0] can_diff;
    logic         fin_ok;

    assign op_stall  = (state_reg != ST_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assign a_val = {op.a3, op.a2, op.a1, op.a0};
    assign b_val = {op.b3, op.b2, op.b1, op.b0};
    assign st    = c25519_pkg::chain_step(pow_reg, step_reg);

    // Working register read: the first operand, then the second.
    always_comb
    begin
        if (state_reg == ST_LDB)
        begin
            slot_ra = st.b;
        end
        else if (st.sqr && (iter_reg != 7'd0))
        begin
            slot_ra = st.dst;
        end
        else
        begin
            slot_ra = st.a;
        end
    end
    assign slot_rd = slot_reg[slot_ra];

    // Shared 32x32 multiplier with the column accumulator.
    assign col_j  = k_reg[2:0] - i_reg;
    assign x_limb = opx_reg[i_reg * 32 +: 32];
    assign y_limb = opy_reg[col_j * 32 +: 32];
    assign prod   = x_limb * y_limb;
    assign msum   = acc_reg + {6'd0, prod};

    // Raw limb value for the fold.
    assign rx = opx_reg[ri_reg * 32 +: 32];
    assign ry = opy_reg[ri_reg * 32 +: 32];
    always_comb
    begin
        case (vsel_reg)
            c25519_pkg::VS_ADD:
                v_limb = {32'd0, rx} + {32'd0, ry};
            c25519_pkg::VS_SUB:
                v_limb = {30'd0, c25519_pkg::three_p_limb(ri_reg)} - {32'd0, ry}
                         + {32'd0, rx};
            c25519_pkg::VS_MUL:
                v_limb = {32'd0, t_reg[31:0]}
                         + {26'd0, 38'(c25519_pkg::K38) * 38'(t_reg[287:256])};
            default:
                v_limb = {15'd0, 49'(c25519_pkg::K121666) * 49'(rx)};
        endcase
    end
    assign u1 = carry_reg + v_limb;
    assign u2 = carry_reg + {32'd0, w_reg[31:0]};

    // Conditional subtraction of p for the canonical form.
    assign can_diff = {1'b0, w_reg} - {1'b0, c25519_pkg::PRIME};

    assign fin_ok = !out_valid_reg || !res_stall;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && res_stall;
        k_next         = k_reg;
        i_next         = i_reg;
        ri_next        = ri_reg;
        step_next      = step_reg;
        iter_next      = iter_reg;
        chain_next     = chain_reg;
        pow_next       = pow_reg;
        can_next       = can_reg;
        cpass_next     = cpass_reg;
        vsel_next      = vsel_reg;
        opx_next       = opx_reg;
        opy_next       = opy_reg;
        t_next         = t_reg;
        w_next         = w_reg;
        acc_next       = acc_reg;
        carry_next     = carry_reg;
        out_next       = out_reg;
        slot_we        = 1'b0;
        slot_wa        = c25519_pkg::SL_Z;
        slot_wd        = w_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    opx_next   = a_val;
                    opy_next   = b_val;
                    chain_next = 1'b0;
                    pow_next   = (op.func == c25519_pkg::FN_POW58);
                    can_next   = (op.func == c25519_pkg::FN_CANON);
                    cpass_next = 1'b0;
                    ri_next    = 3'd0;
                    carry_next = 64'd0;
                    k_next     = 4'd0;
                    i_next     = 3'd0;
                    acc_next   = 70'd0;
                    step_next  = 5'd0;
                    iter_next  = 7'd0;
                    case (op.func) inside
                        c25519_pkg::FN_ADD:
                        begin
                            vsel_next  = c25519_pkg::VS_ADD;
                            state_next = ST_RED1;
                        end
                        c25519_pkg::FN_SUB:
                        begin
                            vsel_next  = c25519_pkg::VS_SUB;
                            state_next = ST_RED1;
                        end
                        c25519_pkg::FN_NEG:
                        begin
                            opx_next   = 256'd0;
                            opy_next   = a_val;
                            vsel_next  = c25519_pkg::VS_SUB;
                            state_next = ST_RED1;
                        end
                        c25519_pkg::FN_MUL:
                        begin
                            vsel_next  = c25519_pkg::VS_MUL;
                            state_next = ST_MUL;
                        end
                        c25519_pkg::FN_SQR:
                        begin
                            opy_next   = a_val;
                            vsel_next  = c25519_pkg::VS_MUL;
                            state_next = ST_MUL;
                        end
                        c25519_pkg::FN_M121:
                        begin
                            vsel_next  = c25519_pkg::VS_M121;
                            state_next = ST_RED1;
                        end
                        c25519_pkg::FN_INV, c25519_pkg::FN_POW58:
                        begin
                            chain_next = 1'b1;
                            vsel_next  = c25519_pkg::VS_MUL;
                            slot_we    = 1'b1;
                            slot_wa    = c25519_pkg::SL_Z;
                            slot_wd    = a_val;
                            state_next = ST_LDA;
                        end
                        c25519_pkg::FN_CANON:
                        begin
                            w_next     = a_val;
                            state_next = ST_CAN;
                        end
                        c25519_pkg::FN_LOAD:
                        begin
                            w_next     = {1'b0, a_val[254:0]};
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            w_next     = 256'd0;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_LDA:
            begin
                opx_next   = slot_rd;
                state_next = ST_LDB;
            end

            ST_LDB:
            begin
                opy_next   = st.sqr ? opx_reg : slot_rd;
                k_next     = 4'd0;
                i_next     = 3'd0;
                acc_next   = 70'd0;
                state_next = ST_MUL;
            end

            // One partial product per cycle, column by column.
            ST_MUL:
            begin
                if (i_reg == col_hi(k_reg))
                begin
                    t_next   = {msum[31:0], t_reg[511:32]};
                    acc_next = {32'd0, msum[69:32]};
                    if (k_reg == 4'd14)
                    begin
                        state_next = ST_MTOP;
                    end
                    else
                    begin
                        k_next = k_reg + 4'd1;
                        i_next = col_lo(k_reg + 4'd1);
                    end
                end
                else
                begin
                    acc_next = msum;
                    i_next   = i_reg + 3'd1;
                end
            end

            ST_MTOP:
            begin
                t_next     = {acc_reg[31:0], t_reg[511:32]};
                ri_next    = 3'd0;
                carry_next = 64'd0;
                state_next = ST_RED1;
            end

            // First fold pass: carry chain to bit 255, then weight the top by 19.
            ST_RED1:
            begin
                t_next = {32'd0, t_reg[511:288], 32'd0, t_reg[255:32]};
                if (ri_reg == 3'd7)
                begin
                    w_next     = {1'b0, u1[30:0], w_reg[255:32]};
                    carry_next = (u1 >> 31) * 64'd19;
                    ri_next    = 3'd0;
                    state_next = ST_RED2;
                end
                else
                begin
                    w_next     = {u1[31:0], w_reg[255:32]};
                    carry_next = u1 >> 32;
                    ri_next    = ri_reg + 3'd1;
                end
            end

            // Second fold pass adds the weighted top back in.
            ST_RED2:
            begin
                w_next     = {u2[31:0], w_reg[255:32]};
                carry_next = u2 >> 32;
                ri_next    = ri_reg + 3'd1;
                if (ri_reg == 3'd7)
                begin
                    ri_next = 3'd0;
                    if (!chain_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        slot_we = 1'b1;
                        slot_wa = st.dst;
                        slot_wd = w_next;
                        if (st.sqr && ((iter_reg + 7'd1) < st.n))
                        begin
                            iter_next  = iter_reg + 7'd1;
                            state_next = ST_LDA;
                        end
                        else if (step_reg == c25519_pkg::STEP_LAST)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            step_next  = step_reg + 5'd1;
                            iter_next  = 7'd0;
                            state_next = ST_LDA;
                        end
                    end
                end
            end

            ST_CAN:
            begin
                if (!can_diff[256])
                begin
                    w_next = can_diff[255:0];
                end
                cpass_next = 1'b1;
                if (cpass_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (fin_ok)
                begin
                    out_valid_next    = 1'b1;
                    out_next.r0       = w_reg[63:0];
                    out_next.r1       = w_reg[127:64];
                    out_next.r2       = w_reg[191:128];
                    out_next.r3       = w_reg[255:192];
                    out_next.is_nonzero = can_reg && (w_reg != 256'd0);
                    out_next.is_odd   = can_reg && w_reg[0];
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= 4'd0;
            i_reg         <= 3'd0;
            ri_reg        <= 3'd0;
            step_reg      <= 5'd0;
            iter_reg      <= 7'd0;
            chain_reg     <= 1'b0;
            pow_reg       <= 1'b0;
            can_reg       <= 1'b0;
            cpass_reg     <= 1'b0;
            vsel_reg      <= c25519_pkg::VS_ADD;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            ri_reg        <= ri_next;
            step_reg      <= step_next;
            iter_reg      <= iter_next;
            chain_reg     <= chain_next;
            pow_reg       <= pow_next;
            can_reg       <= can_next;
            cpass_reg     <= cpass_next;
            vsel_reg      <= vsel_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        opx_reg   <= opx_next;
        opy_reg   <= opy_next;
        t_reg     <= t_next;
        w_reg     <= w_next;
        acc_reg   <= acc_next;
        carry_reg <= carry_next;
        out_reg   <= out_next;
        if (slot_we)
        begin
            slot_reg[slot_wa] <= slot_wd;
        end
    end

    // A flagged odd value is never zero.
    a_odd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.is_odd |-> res.is_nonzero)
        else $error("odd flag without nonzero flag");

    // The row index stays inside the current product column.
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (i_reg >= col_lo(k_reg)) && (i_reg <= col_hi(k_reg))
            && (k_reg <= 4'd14))
        else $error("multiplier index out of column");

    // The chain program counter never runs past its last step.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        chain_reg && (state_reg != ST_IDLE) |-> step_reg <= c25519_pkg::STEP_LAST)
        else $error("chain step out of range");

    // A new result appears only from the finish state.
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside finish");

endmodule
